[hdl/etsu_pkg.sv]
// Package of the expression token scanner: payload types, scan modes, token kinds,
// character codes and the fixed-point fraction constants. No dependencies.
package etsu_pkg;

   localparam int LINE_WIDTH    = 16;
   localparam int OFFSET_WIDTH  = 32;
   localparam int FRAC_BITS     = 16;
   localparam int INT_BITS      = 64 - FRAC_BITS;
   localparam int DIGITS_WIDTH  = 17;
   localparam int QUEUE_DEPTH   = 4;
   localparam int TOK_SLOTS     = 3;

   localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};
   localparam logic [INT_BITS-1:0]   INT_MAX  = {INT_BITS{1'b1}};
   localparam logic [15:0]           LEN_MAX  = 16'hFFFF;

   // Reciprocal multipliers for the decimal fraction: floor(d * 2^F / 10^n)
   // equals (d * FRAC_MUL_n) >> FRAC_SHIFT_n for every d below 10^n.
   localparam int FRAC_SHIFT_1 = 7;
   localparam int FRAC_SHIFT_2 = 14;
   localparam int FRAC_SHIFT_3 = 20;
   localparam int FRAC_SHIFT_4 = 27;
   localparam int FRAC_SHIFT_5 = 34;
   localparam int FRAC_MUL_WIDTH = 36;
   localparam logic [FRAC_MUL_WIDTH-1:0] FRAC_MUL_1 =
      FRAC_MUL_WIDTH'(((64'd1 << (FRAC_SHIFT_1 + FRAC_BITS)) + 64'd9) / 64'd10);
   localparam logic [FRAC_MUL_WIDTH-1:0] FRAC_MUL_2 =
      FRAC_MUL_WIDTH'(((64'd1 << (FRAC_SHIFT_2 + FRAC_BITS)) + 64'd99) / 64'd100);
   localparam logic [FRAC_MUL_WIDTH-1:0] FRAC_MUL_3 =
      FRAC_MUL_WIDTH'(((64'd1 << (FRAC_SHIFT_3 + FRAC_BITS)) + 64'd999) / 64'd1000);
   localparam logic [FRAC_MUL_WIDTH-1:0] FRAC_MUL_4 =
      FRAC_MUL_WIDTH'(((64'd1 << (FRAC_SHIFT_4 + FRAC_BITS)) + 64'd9999) / 64'd10000);
   localparam logic [FRAC_MUL_WIDTH-1:0] FRAC_MUL_5 =
      FRAC_MUL_WIDTH'(((64'd1 << (FRAC_SHIFT_5 + FRAC_BITS)) + 64'd99999) / 64'd100000);

   // Token kinds.
   localparam logic [4:0] KIND_END     = 5'd0;
   localparam logic [4:0] KIND_AT      = 5'd1;
   localparam logic [4:0] KIND_LBRACE  = 5'd2;
   localparam logic [4:0] KIND_RBRACE  = 5'd3;
   localparam logic [4:0] KIND_LPAREN  = 5'd4;
   localparam logic [4:0] KIND_RPAREN  = 5'd5;
   localparam logic [4:0] KIND_LBRACK  = 5'd6;
   localparam logic [4:0] KIND_RBRACK  = 5'd7;
   localparam logic [4:0] KIND_CARET   = 5'd8;
   localparam logic [4:0] KIND_ASSIGN  = 5'd9;
   localparam logic [4:0] KIND_COMMA   = 5'd10;
   localparam logic [4:0] KIND_PIPE    = 5'd11;
   localparam logic [4:0] KIND_SEMI    = 5'd12;
   localparam logic [4:0] KIND_DOT     = 5'd13;
   localparam logic [4:0] KIND_DOT_EQ  = 5'd14;
   localparam logic [4:0] KIND_PLUS    = 5'd15;
   localparam logic [4:0] KIND_PLUS_EQ = 5'd16;
   localparam logic [4:0] KIND_INC     = 5'd17;
   localparam logic [4:0] KIND_MINUS   = 5'd18;
   localparam logic [4:0] KIND_MIN_EQ  = 5'd19;
   localparam logic [4:0] KIND_DEC     = 5'd20;
   localparam logic [4:0] KIND_STAR    = 5'd21;
   localparam logic [4:0] KIND_STAR_EQ = 5'd22;
   localparam logic [4:0] KIND_SLASH   = 5'd23;
   localparam logic [4:0] KIND_SLSH_EQ = 5'd24;
   localparam logic [4:0] KIND_STRING  = 5'd25;
   localparam logic [4:0] KIND_NUMBER  = 5'd26;
   localparam logic [4:0] KIND_IDENT   = 5'd27;
   localparam logic [4:0] KIND_UNKNOWN = 5'd28;
   localparam logic [4:0] KIND_NONE    = 5'd0;

   // Character codes.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   typedef enum logic [4:0] {
      MODE_IDLE, MODE_OP_DOT, MODE_OP_PLUS, MODE_OP_MINUS, MODE_OP_STAR, MODE_OP_SLASH,
      MODE_LINE_COMMENT, MODE_BLOCK, MODE_BLOCK_STAR, MODE_STRING, MODE_IDENT,
      MODE_NUM_LEAD, MODE_DEC_INT, MODE_DEC_DOT, MODE_DEC_FRAC, MODE_BIN, MODE_HEX
   } scan_mode_type;

   typedef struct packed {
      logic       command;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] line_number;
      logic [15:0] column_number;
      logic [7:0]  char_value;
      logic [63:0] number_value;
      logic [31:0] text_start;
      logic [15:0] text_length;
      logic        first_on_line;
      logic        last_result;
   } rsp_type;

   // A source byte after classification by the front end.
   typedef struct packed {
      logic       is_end;
      logic [7:0] ch;
      logic       is_space;
      logic       is_digit;
      logic       is_letter;
      logic       is_hex;
      logic [3:0] digit_value;
      logic [4:0] single_kind;
   } cls_item_type;

endpackage

[hdl/etsu_front.sv]
// Front end of the token scanner: classifies each source byte for the scan engine.
// Depends on etsu_pkg.
module etsu_front
   import etsu_pkg::*;
(
   input  req_type      req_data,
   output cls_item_type cls_item
);

   logic [7:0] c;

   assign c = req_data.char_byte;

   always_comb begin
      cls_item.is_end    = req_data.command || (c == CH_NUL);
      cls_item.ch        = c;
      cls_item.is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
      cls_item.is_digit  = (c inside {[8'h30:8'h39]});
      cls_item.is_letter = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
      cls_item.is_hex    = 1'b1;
      cls_item.digit_value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         cls_item.digit_value = 4'(c - CH_ZERO);
      end else if (c inside {[8'h61:8'h66]}) begin
         cls_item.digit_value = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         cls_item.digit_value = 4'(c - 8'h37);
      end else begin
         cls_item.is_hex = 1'b0;
      end
      case (c)
         8'h40:   cls_item.single_kind = KIND_AT;
         8'h7B:   cls_item.single_kind = KIND_LBRACE;
         8'h7D:   cls_item.single_kind = KIND_RBRACE;
         8'h28:   cls_item.single_kind = KIND_LPAREN;
         8'h29:   cls_item.single_kind = KIND_RPAREN;
         8'h5B:   cls_item.single_kind = KIND_LBRACK;
         8'h5D:   cls_item.single_kind = KIND_RBRACK;
         8'h5E:   cls_item.single_kind = KIND_CARET;
         8'h3D:   cls_item.single_kind = KIND_ASSIGN;
         8'h2C:   cls_item.single_kind = KIND_COMMA;
         8'h7C:   cls_item.single_kind = KIND_PIPE;
         8'h3B:   cls_item.single_kind = KIND_SEMI;
         default: cls_item.single_kind = KIND_NONE;
      endcase
   end

endmodule

[hdl/etsu_queue.sv]
// Short queue of classified bytes between the front end and the scan engine.
// Depends on etsu_pkg.
module etsu_queue
   import etsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cls_item_type push_item,
   output logic         full,
   input  logic         pop,
   output cls_item_type pop_item,
   output logic         empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cls_item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = (PTR_W+1)'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = (PTR_W+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/etsu_back.sv]
// Scan engine: runs the token scan state machine on one classified byte per cycle
// while its token buffer is free, and holds its tokens until taken. Depends on etsu_pkg.
module etsu_back
   import etsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cls_item_type item,
   input  logic         item_empty,
   output logic         item_pop,
   output rsp_type      rsp_data,
   output logic         rsp_empty,
   input  logic         rsp_pop
);

   typedef struct packed {
      scan_mode_type            mode;
      logic [OFFSET_WIDTH-1:0]  offset;
      logic [LINE_WIDTH-1:0]    line;
      logic [LINE_WIDTH-1:0]    col;
      logic [LINE_WIDTH-1:0]    tok_line;
      logic [LINE_WIDTH-1:0]    tok_col;
      logic [OFFSET_WIDTH-1:0]  tok_offset;
      logic [INT_BITS-1:0]      acc;
      logic [DIGITS_WIDTH-1:0]  frac_digits;
      logic [2:0]               frac_count;
      logic                     new_line;
   } scan_state_type;

   typedef struct packed {
      logic [1:0]                count;
      rsp_type [TOK_SLOTS-1:0]   tok;
   } tok_list_type;

   scan_state_type state_ff, state_in, scan_s;
   tok_list_type   scan_l;
   rsp_type        slot_ff [TOK_SLOTS];
   logic [1:0]     cnt_ff, cnt_in;
   logic [1:0]     head_ff, head_in;
   logic           take;
   logic           do_pop;
   logic [FRAC_MUL_WIDTH-1:0]              frac_mul;
   logic [5:0]                             frac_shift;
   logic [DIGITS_WIDTH+FRAC_MUL_WIDTH-1:0] frac_prod;
   logic [FRAC_BITS-1:0]                   frac_value;

   function automatic void consume(inout scan_state_type s, input cls_item_type c);
      s.offset = OFFSET_WIDTH'(s.offset + 1'b1);
      if (c.ch == CH_LF) begin
         if (s.line != LINE_MAX) s.line = LINE_WIDTH'(s.line + 1'b1);
         s.col      = '0;
         s.new_line = 1'b1;
      end else if (s.col != LINE_MAX) begin
         s.col = LINE_WIDTH'(s.col + 1'b1);
      end
   endfunction

   function automatic void mark_start(inout scan_state_type s);
      s.tok_line = s.line;
      s.tok_col  = s.col;
   endfunction

   function automatic void emit(inout scan_state_type s, inout tok_list_type l,
                                input logic [4:0] kind, input logic [7:0] ch,
                                input logic [63:0] num, input logic [31:0] start,
                                input logic [15:0] len);
      rsp_type t;
      t.token_kind    = kind;
      t.line_number   = s.tok_line;
      t.column_number = s.tok_col;
      t.char_value    = ch;
      t.number_value  = num;
      t.text_start    = start;
      t.text_length   = len;
      t.first_on_line = s.new_line;
      t.last_result   = 1'b0;
      if (l.count != 2'd3) begin
         l.tok[l.count] = t;
         l.count        = 2'(l.count + 1'b1);
      end
      s.new_line = 1'b0;
   endfunction

   function automatic void emit_text(inout scan_state_type s, inout tok_list_type l,
                                     input logic [4:0] kind);
      emit(s, l, kind, CH_NUL, 64'd0, s.tok_offset, s.acc[15:0]);
   endfunction

   function automatic void emit_number(inout scan_state_type s, inout tok_list_type l,
                                       input logic [FRAC_BITS-1:0] frac);
      emit(s, l, KIND_NUMBER, CH_NUL, {s.acc, frac}, 32'd0, 16'd0);
   endfunction

   function automatic logic [4:0] op_kind(input scan_mode_type m);
      case (m)
         MODE_OP_DOT:   return KIND_DOT;
         MODE_OP_PLUS:  return KIND_PLUS;
         MODE_OP_MINUS: return KIND_MINUS;
         MODE_OP_STAR:  return KIND_STAR;
         default:       return KIND_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] op_char(input scan_mode_type m);
      case (m)
         MODE_OP_DOT:   return CH_DOT;
         MODE_OP_PLUS:  return CH_PLUS;
         MODE_OP_MINUS: return CH_MINUS;
         MODE_OP_STAR:  return CH_STAR;
         default:       return CH_SLASH;
      endcase
   endfunction

   // Saturating digit step: acc * base + d, clipped to the largest integer part.
   function automatic logic [INT_BITS-1:0] accumulate(input logic [INT_BITS-1:0] a,
                                                      input logic [1:0] base_sel,
                                                      input logic [3:0] d);
      logic [INT_BITS+4:0] wide;
      case (base_sel)
         2'd0:    wide = ((INT_BITS+5)'(a) << 1) + (INT_BITS+5)'(d);
         2'd1:    wide = ((INT_BITS+5)'(a) << 3) + ((INT_BITS+5)'(a) << 1)
                         + (INT_BITS+5)'(d);
         default: wide = ((INT_BITS+5)'(a) << 4) + (INT_BITS+5)'(d);
      endcase
      if (wide > (INT_BITS+5)'(INT_MAX)) return INT_MAX;
      return wide[INT_BITS-1:0];
   endfunction

   function automatic void fresh(inout scan_state_type s, inout tok_list_type l,
                                 input cls_item_type c);
      consume(s, c);
      s.mode = MODE_IDLE;
      mark_start(s);
      if (c.is_space) begin
         s.mode = MODE_IDLE;
      end else if (c.single_kind != KIND_NONE) begin
         emit(s, l, c.single_kind, c.ch, 64'd0, 32'd0, 16'd0);
      end else if (c.ch == CH_DOT) begin
         s.mode = MODE_OP_DOT;
      end else if (c.ch == CH_PLUS) begin
         s.mode = MODE_OP_PLUS;
      end else if (c.ch == CH_MINUS) begin
         s.mode = MODE_OP_MINUS;
      end else if (c.ch == CH_STAR) begin
         s.mode = MODE_OP_STAR;
      end else if (c.ch == CH_SLASH) begin
         s.mode = MODE_OP_SLASH;
      end else if (c.ch == CH_QUOTE) begin
         s.tok_offset = s.offset;
         s.acc        = '0;
         s.mode       = MODE_STRING;
      end else if (c.is_digit) begin
         s.acc         = INT_BITS'(c.digit_value);
         s.frac_digits = '0;
         s.frac_count  = '0;
         s.mode        = MODE_NUM_LEAD;
      end else if (c.is_letter) begin
         s.tok_offset = OFFSET_WIDTH'(s.offset - 1'b1);
         s.acc        = INT_BITS'(1);
         s.mode       = MODE_IDENT;
      end else begin
         emit(s, l, KIND_UNKNOWN, c.ch, 64'd0, 32'd0, 16'd0);
      end
   endfunction

   function automatic void op_pending(inout scan_state_type s, inout tok_list_type l,
                                      input cls_item_type c);
      logic [4:0] pair;
      pair = KIND_NONE;
      if (c.ch == CH_EQ) begin
         case (s.mode)
            MODE_OP_DOT:   pair = KIND_DOT_EQ;
            MODE_OP_PLUS:  pair = KIND_PLUS_EQ;
            MODE_OP_MINUS: pair = KIND_MIN_EQ;
            MODE_OP_STAR:  pair = KIND_STAR_EQ;
            default:       pair = KIND_SLSH_EQ;
         endcase
      end else if (c.ch == CH_PLUS && s.mode == MODE_OP_PLUS) begin
         pair = KIND_INC;
      end else if (c.ch == CH_MINUS && s.mode == MODE_OP_MINUS) begin
         pair = KIND_DEC;
      end
      if (pair != KIND_NONE) begin
         consume(s, c);
         emit(s, l, pair, CH_NUL, 64'd0, 32'd0, 16'd0);
         s.mode = MODE_IDLE;
      end else if (s.mode == MODE_OP_SLASH && (c.ch == CH_SLASH || c.ch == CH_STAR)) begin
         consume(s, c);
         s.mode = (c.ch == CH_SLASH) ? MODE_LINE_COMMENT : MODE_BLOCK;
      end else begin
         emit(s, l, op_kind(s.mode), op_char(s.mode), 64'd0, 32'd0, 16'd0);
         fresh(s, l, c);
      end
   endfunction

   function automatic void dec_int(inout scan_state_type s, inout tok_list_type l,
                                   input cls_item_type c, input logic [FRAC_BITS-1:0] frac);
      if (c.is_digit) begin
         consume(s, c);
         s.acc = accumulate(s.acc, 2'd1, c.digit_value);
      end else if (c.ch == CH_UNDER) begin
         consume(s, c);
      end else if (c.ch == CH_DOT) begin
         consume(s, c);
         s.mode = MODE_DEC_DOT;
      end else begin
         emit_number(s, l, frac);
         fresh(s, l, c);
      end
   endfunction

   // Fraction bits of the pending number, from the registered digits and count.
   always_comb begin
      case (state_ff.frac_count)
         3'd1:    begin frac_mul = FRAC_MUL_1; frac_shift = 6'(FRAC_SHIFT_1); end
         3'd2:    begin frac_mul = FRAC_MUL_2; frac_shift = 6'(FRAC_SHIFT_2); end
         3'd3:    begin frac_mul = FRAC_MUL_3; frac_shift = 6'(FRAC_SHIFT_3); end
         3'd4:    begin frac_mul = FRAC_MUL_4; frac_shift = 6'(FRAC_SHIFT_4); end
         3'd5:    begin frac_mul = FRAC_MUL_5; frac_shift = 6'(FRAC_SHIFT_5); end
         default: begin frac_mul = '0; frac_shift = '0; end
      endcase
      frac_prod  = (DIGITS_WIDTH+FRAC_MUL_WIDTH)'(state_ff.frac_digits) *
                   (DIGITS_WIDTH+FRAC_MUL_WIDTH)'(frac_mul);
      frac_value = FRAC_BITS'(frac_prod >> frac_shift);
   end

   always_comb begin
      scan_s       = state_ff;
      scan_l.count = 2'd0;
      scan_l.tok   = '0;
      if (item.is_end) begin
         case (scan_s.mode)
            MODE_OP_DOT, MODE_OP_PLUS, MODE_OP_MINUS, MODE_OP_STAR, MODE_OP_SLASH: begin
               emit(scan_s, scan_l, op_kind(scan_s.mode), op_char(scan_s.mode),
                    64'd0, 32'd0, 16'd0);
            end
            MODE_STRING: emit_text(scan_s, scan_l, KIND_STRING);
            MODE_IDENT:  emit_text(scan_s, scan_l, KIND_IDENT);
            MODE_NUM_LEAD, MODE_DEC_INT, MODE_DEC_FRAC, MODE_BIN, MODE_HEX: begin
               emit_number(scan_s, scan_l, frac_value);
            end
            MODE_DEC_DOT: begin
               emit_number(scan_s, scan_l, frac_value);
               mark_start(scan_s);
               emit(scan_s, scan_l, KIND_DOT, CH_DOT, 64'd0, 32'd0, 16'd0);
            end
            default: begin
            end
         endcase
         scan_s.mode = MODE_IDLE;
         mark_start(scan_s);
         emit(scan_s, scan_l, KIND_END, CH_NUL, 64'd0, 32'd0, 16'd0);
      end else begin
         case (scan_s.mode)
            MODE_IDLE: fresh(scan_s, scan_l, item);
            MODE_OP_DOT, MODE_OP_PLUS, MODE_OP_MINUS, MODE_OP_STAR, MODE_OP_SLASH: begin
               op_pending(scan_s, scan_l, item);
            end
            MODE_LINE_COMMENT: begin
               consume(scan_s, item);
               if (item.ch == CH_LF) scan_s.mode = MODE_IDLE;
            end
            MODE_BLOCK: begin
               consume(scan_s, item);
               if (item.ch == CH_STAR) scan_s.mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               consume(scan_s, item);
               if (item.ch == CH_SLASH) scan_s.mode = MODE_IDLE;
               else if (item.ch != CH_STAR) scan_s.mode = MODE_BLOCK;
            end
            MODE_STRING: begin
               consume(scan_s, item);
               if (item.ch == CH_QUOTE || item.ch == CH_LF) begin
                  emit_text(scan_s, scan_l, KIND_STRING);
                  scan_s.mode = MODE_IDLE;
               end else if (scan_s.acc[15:0] != LEN_MAX) begin
                  scan_s.acc = INT_BITS'(scan_s.acc + 1'b1);
               end
            end
            MODE_IDENT: begin
               if (item.is_letter || item.is_digit || item.ch == CH_UNDER) begin
                  consume(scan_s, item);
                  if (scan_s.acc[15:0] != LEN_MAX) scan_s.acc = INT_BITS'(scan_s.acc + 1'b1);
               end else begin
                  emit_text(scan_s, scan_l, KIND_IDENT);
                  fresh(scan_s, scan_l, item);
               end
            end
            MODE_NUM_LEAD: begin
               if (item.ch == CH_LOWER_B || item.ch == CH_UPPER_B ||
                   item.ch == CH_LOWER_X || item.ch == CH_UPPER_X) begin
                  consume(scan_s, item);
                  scan_s.acc  = '0;
                  scan_s.mode = (item.ch == CH_LOWER_B || item.ch == CH_UPPER_B) ?
                                MODE_BIN : MODE_HEX;
               end else begin
                  scan_s.mode = MODE_DEC_INT;
                  dec_int(scan_s, scan_l, item, frac_value);
               end
            end
            MODE_DEC_INT: dec_int(scan_s, scan_l, item, frac_value);
            MODE_DEC_DOT: begin
               if (item.is_digit) begin
                  consume(scan_s, item);
                  scan_s.frac_digits = DIGITS_WIDTH'(item.digit_value);
                  scan_s.frac_count  = 3'd1;
                  scan_s.mode        = MODE_DEC_FRAC;
               end else begin
                  emit_number(scan_s, scan_l, frac_value);
                  mark_start(scan_s);
                  scan_s.mode = MODE_OP_DOT;
                  op_pending(scan_s, scan_l, item);
               end
            end
            MODE_DEC_FRAC: begin
               if (item.is_digit) begin
                  consume(scan_s, item);
                  if (scan_s.frac_count < 3'd5) begin
                     scan_s.frac_digits = DIGITS_WIDTH'((scan_s.frac_digits << 3) +
                                          (scan_s.frac_digits << 1) +
                                          DIGITS_WIDTH'(item.digit_value));
                     scan_s.frac_count  = 3'(scan_s.frac_count + 1'b1);
                  end
               end else if (item.ch == CH_UNDER) begin
                  consume(scan_s, item);
               end else begin
                  emit_number(scan_s, scan_l, frac_value);
                  fresh(scan_s, scan_l, item);
               end
            end
            MODE_BIN: begin
               if (item.ch == CH_ZERO || item.ch == CH_ONE) begin
                  consume(scan_s, item);
                  scan_s.acc = accumulate(scan_s.acc, 2'd0, item.digit_value);
               end else if (item.ch == CH_UNDER) begin
                  consume(scan_s, item);
               end else begin
                  emit_number(scan_s, scan_l, frac_value);
                  fresh(scan_s, scan_l, item);
               end
            end
            MODE_HEX: begin
               if (item.is_hex) begin
                  consume(scan_s, item);
                  scan_s.acc = accumulate(scan_s.acc, 2'd2, item.digit_value);
               end else if (item.ch == CH_UNDER) begin
                  consume(scan_s, item);
               end else begin
                  emit_number(scan_s, scan_l, frac_value);
                  fresh(scan_s, scan_l, item);
               end
            end
            default: fresh(scan_s, scan_l, item);
         endcase
      end
      if (scan_l.count != 2'd0) begin
         scan_l.tok[2'(scan_l.count - 1'b1)].last_result = 1'b1;
      end
   end

   // A new byte is scanned once the token buffer is empty or being emptied now.
   assign do_pop    = rsp_pop && (cnt_ff != 2'd0);
   assign take      = !item_empty && ((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && do_pop));
   assign item_pop  = take;
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = slot_ff[head_ff];

   always_comb begin
      state_in = take ? scan_s : state_ff;
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      if (take) begin
         cnt_in  = scan_l.count;
         head_in = 2'd0;
      end else if (do_pop) begin
         cnt_in  = 2'(cnt_ff - 1'b1);
         head_in = 2'(head_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= 2'd0;
         head_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < TOK_SLOTS; i++) begin
            slot_ff[i] <= scan_l.tok[i];
         end
      end
   end

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      (3'(cnt_ff) + 3'(head_ff)) <= 3'(TOK_SLOTS))
      else $error("token buffer head and count run past the slots");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> rsp_data.last_result)
      else $error("final buffered token lacks the last-result mark");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > 2'd1) |=> (cnt_ff != 2'd0) || $past(do_pop))
      else $error("token buffer lost tokens without a transfer");

endmodule

[hdl/expression_token_scanner_unit.sv]
// Top level of the expression token scanner: front end, byte queue and scan engine.
// Depends on etsu_pkg, etsu_front, etsu_queue and etsu_back.

// The scanner takes one source byte, or an end-of-text mark, per transfer and
// produces tokens on a queue-style result port, one token per transfer. A byte
// enters while the queue has room: it is classified, waits in a four-entry queue,
// and the engine consumes one byte per cycle if the byte before it caused at most
// one token and it is taken. A byte that causes two or three tokens (an identifier
// or number closed by an operator, or an end mark closing a number with a trailing
// dot) holds the engine until its last token is taken, since the result side drains
// one token per cycle; the queue absorbs such bursts. Every token carries its line,
// its column after its first character, and a mark when it is the first token on a
// new line; the last token caused by one input item carries last_result. Numbers
// come out as 48.16 unsigned fixed point, the integer part saturating and fraction
// digits past the fifth ignored. Reset is synchronous and needs no clearing pass.
module expression_token_scanner_unit
   import etsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   cls_item_type cls_in;
   cls_item_type cls_out;
   logic         q_empty;
   logic         q_pop;

   // Classification sits ahead of the queue, so the engine sees ready-made flags.
   etsu_front u_front (
      .req_data (req_data),
      .cls_item (cls_in)
   );

   etsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (cls_in),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (cls_out),
      .empty     (q_empty)
   );

   // The engine holds up to three tokens and refills as the last one transfers.
   etsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (cls_out),
      .item_empty (q_empty),
      .item_pop   (q_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule
